// File: rtl/core/ggsc_pkg.sv
// Types, constants and the arctangent table for the go-to-goal steering controller.
`default_nettype none

package ggsc_pkg;

   // Field widths
   localparam int POS_W   = 16;
   localparam int HEAD_W  = 16;
   localparam int LIN_W   = 16;
   localparam int ANG_W   = 18;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Internal datapath widths
   localparam int DELTA_W = 17;  // goal minus pose, Q.8
   localparam int XY_W    = 27;  // CORDIC x/y with 8 guard bits and gain growth
   localparam int Z_W     = 19;  // accumulated angle, Q.16 radians
   localparam int DIST_W  = 17;  // distance, Q9.8
   localparam int DIFF_W  = 21;  // bearing minus heading, Q.16
   localparam int MA_W    = 28;
   localparam int MB_W    = 18;
   localparam int P_W     = MA_W + MB_W;
   localparam int TBL_IDX_W = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_TOL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_GAIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_GAIN  = 3'd4;

   // Register reset values
   localparam logic [15:0] GOAL_X_RST       = 16'd256;
   localparam logic [15:0] GOAL_Y_RST       = 16'd256;
   localparam logic [15:0] ARRIVE_TOL_RST   = 16'd3;
   localparam logic [15:0] LINEAR_GAIN_RST  = 16'd256;
   localparam logic [7:0]  ANGULAR_GAIN_RST = 8'd64;

   // Arithmetic constants
   localparam logic [MB_W-1:0]       INV_GAIN_Q16 = 18'd39797;
   localparam logic signed [Z_W-1:0] HALF_PI_Q16  = 19'sd102944;
   localparam logic signed [P_W-1:0] DIST_RND     = 46'sd8388608;
   localparam logic signed [P_W-1:0] VEL_RND      = 46'sd128;
   localparam logic signed [P_W-1:0] ANG_MAX      = 46'sd131071;
   localparam logic signed [P_W-1:0] ANG_MIN      = -46'sd131072;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_MDIST,
      ST_DIST,
      ST_MLIN,
      ST_MANG,
      ST_ANG,
      ST_OUT
   } state_type;

   // atan(2^-i) in Q.16 radians, rounded to nearest
   function automatic logic [15:0] atan_q16(input logic [TBL_IDX_W-1:0] idx);
      logic [15:0] v;
      begin
         case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ggsc_if.sv
// Pose request and velocity response channel interfaces.
`default_nettype none

interface ggsc_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [ggsc_pkg::POS_W-1:0]  pose_x;
   logic signed [ggsc_pkg::POS_W-1:0]  pose_y;
   logic signed [ggsc_pkg::HEAD_W-1:0] pose_heading;

   modport source (output valid, output pose_x, output pose_y, output pose_heading,
                   input ready);
   modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                   output ready);
endinterface

interface ggsc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ggsc_pkg::LIN_W-1:0]        linear_velocity;
   logic signed [ggsc_pkg::ANG_W-1:0] angular_velocity;
   logic                              goal_reached;

   modport source (output valid, output linear_velocity, output angular_velocity,
                   output goal_reached, input ready);
   modport sink   (input valid, input linear_velocity, input angular_velocity,
                   input goal_reached, output ready);
endinterface

`default_nettype wire

// File: rtl/core/go_to_goal_steering_controller_core.sv
// Go-to-goal steering controller: CORDIC vectoring plus proportional velocity commands.
//
// One pose transaction produces one velocity transaction. The block takes a pose only
// when its sequencer is idle: a pose is held from acceptance through the vectoring loop
// and the product states, or through the product states alone when the pose sits exactly
// on the goal. The vectoring loop runs one micro-rotation per cycle through a single
// shift-add unit, followed by three products (distance scaling, linear gain, angular
// gain) through one shared 28x18 multiplier with a rounding/saturation step after
// each. The finished result is held in an output register, so the next pose may be
// accepted while the previous result still waits; if that register is still occupied
// when the next result is ready, the sequencer holds in its last state for as long
// as the receiver stalls.
// Register writes are taken at any time but are meant to be made while idle.
`default_nettype none

module go_to_goal_steering_controller_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   ggsc_req_if.sink                          req_ch,
   ggsc_rsp_if.source                        rsp_ch,
   input  wire                               csr_write_enable,
   input  wire [ggsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [ggsc_pkg::CSR_W-1:0]         csr_write_data
);
   import ggsc_pkg::*;

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   // Configuration registers
   logic signed [POS_W-1:0] goal_x_ff, goal_y_ff;
   logic [15:0]             tol_ff, lin_gain_ff;
   logic [7:0]              ang_gain_ff;

   // Sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic signed [HEAD_W-1:0] heading_ff, heading_in;
   logic signed [P_W-1:0]   prod_ff, prod_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic [LIN_W-1:0]        lin_ff, lin_in;
   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic                    latch_ff, latch_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LIN_W-1:0]        rsp_lin_ff, rsp_lin_in;
   logic signed [ANG_W-1:0] rsp_ang_ff, rsp_ang_in;
   logic                    rsp_reached_ff, rsp_reached_in;

   // Combinational helpers
   logic signed [DELTA_W-1:0] dx, dy;
   logic signed [XY_W-1:0]    x0, y0, xs, ys;
   logic signed [Z_W-1:0]     atan_z;
   logic signed [DIFF_W-1:0]  ang_diff;
   logic signed [MA_W-1:0]    mul_a;
   logic signed [MB_W-1:0]    mul_b;
   logic signed [P_W-1:0]     mul_p, rnd_sum, ang_shift;
   logic                      req_fire, out_free, hit;

   assign req_ch.ready            = (state_ff == ST_IDLE);
   assign req_fire                = req_ch.valid && req_ch.ready;
   assign out_free                = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.linear_velocity  = rsp_lin_ff;
   assign rsp_ch.angular_velocity = rsp_ang_ff;
   assign rsp_ch.goal_reached     = rsp_reached_ff;

   // Goal-relative vector with guard bits
   assign dx = {goal_x_ff[POS_W-1], goal_x_ff} - {req_ch.pose_x[POS_W-1], req_ch.pose_x};
   assign dy = {goal_y_ff[POS_W-1], goal_y_ff} - {req_ch.pose_y[POS_W-1], req_ch.pose_y};
   assign x0 = {{(XY_W-DELTA_W-8){dx[DELTA_W-1]}}, dx, 8'b0};
   assign y0 = {{(XY_W-DELTA_W-8){dy[DELTA_W-1]}}, dy, 8'b0};

   // Shared shift-add unit operands
   assign xs     = x_ff >>> step_ff;
   assign ys     = y_ff >>> step_ff;
   assign atan_z = Z_W'(signed'({1'b0, atan_q16(TBL_IDX_W'(step_ff))}));

   // Bearing minus heading, both in Q.16
   assign ang_diff = {{(DIFF_W-Z_W){z_ff[Z_W-1]}}, z_ff}
                   - {heading_ff[HEAD_W-1], heading_ff, 4'b0};

   // Shared multiplier
   assign mul_p = mul_a * mul_b;

   // Sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      heading_in    = heading_ff;
      prod_in       = prod_ff;
      dist_in       = dist_ff;
      lin_in        = lin_ff;
      ang_in        = ang_ff;
      latch_in      = latch_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_lin_in    = rsp_lin_ff;
      rsp_ang_in    = rsp_ang_ff;
      rsp_reached_in = rsp_reached_ff;
      mul_a         = '0;
      mul_b         = '0;
      rnd_sum       = '0;
      ang_shift     = '0;
      hit           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               heading_in = req_ch.pose_heading;
               step_in    = '0;
               if (dx == '0 && dy == '0) begin
                  x_in     = '0;
                  y_in     = '0;
                  z_in     = '0;
                  state_in = ST_MDIST;
               end else begin
                  state_in = ST_ROT;
                  if (dx[DELTA_W-1]) begin
                     // pre-rotate into the right half-plane
                     if (!dy[DELTA_W-1]) begin
                        x_in = y0;
                        y_in = -x0;
                        z_in = HALF_PI_Q16;
                     end else begin
                        x_in = -y0;
                        y_in = x0;
                        z_in = -HALF_PI_Q16;
                     end
                  end else begin
                     x_in = x0;
                     y_in = y0;
                     z_in = '0;
                  end
               end
            end
         end
         ST_ROT: begin
            // one micro-rotation, driving y towards zero
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_z;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_z;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_MDIST;
            end
         end
         ST_MDIST: begin
            // scale magnitude by the inverse CORDIC gain
            mul_a    = x_ff[XY_W-1] ? '0 : MA_W'(x_ff);
            mul_b    = INV_GAIN_Q16;
            prod_in  = mul_p;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            rnd_sum  = prod_ff + DIST_RND;
            dist_in  = rnd_sum[16+8+DIST_W-1:16+8];
            state_in = ST_MLIN;
         end
         ST_MLIN: begin
            // arrival check and linear gain product
            hit      = latch_ff || (dist_ff <= {1'b0, tol_ff});
            latch_in = hit;
            mul_a    = MA_W'({1'b0, dist_ff});
            mul_b    = MB_W'({1'b0, lin_gain_ff});
            prod_in  = mul_p;
            state_in = ST_MANG;
         end
         ST_MANG: begin
            rnd_sum  = prod_ff + VEL_RND;
            lin_in   = (|rnd_sum[P_W-1:LIN_W+8]) ? {LIN_W{1'b1}} : rnd_sum[LIN_W+7:8];
            mul_a    = MA_W'(ang_diff);
            mul_b    = MB_W'({1'b0, ang_gain_ff});
            prod_in  = mul_p;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            rnd_sum   = prod_ff + VEL_RND;
            ang_shift = rnd_sum >>> 8;
            if (ang_shift > ANG_MAX) begin
               ang_in = ANG_MAX[ANG_W-1:0];
            end else if (ang_shift < ANG_MIN) begin
               ang_in = ANG_MIN[ANG_W-1:0];
            end else begin
               ang_in = ang_shift[ANG_W-1:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand over to the output register once it is free
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_reached_in = latch_ff;
               rsp_lin_in     = latch_ff ? '0 : lin_ff;
               rsp_ang_in     = latch_ff ? '0 : ang_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         latch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and output payload
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      heading_ff     <= heading_in;
      prod_ff        <= prod_in;
      dist_ff        <= dist_in;
      lin_ff         <= lin_in;
      ang_ff         <= ang_in;
      rsp_lin_ff     <= rsp_lin_in;
      rsp_ang_ff     <= rsp_ang_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff   <= GOAL_X_RST;
         goal_y_ff   <= GOAL_Y_RST;
         tol_ff      <= ARRIVE_TOL_RST;
         lin_gain_ff <= LINEAR_GAIN_RST;
         ang_gain_ff <= ANGULAR_GAIN_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GOAL_X:       goal_x_ff   <= csr_write_data;
            CSR_GOAL_Y:       goal_y_ff   <= csr_write_data;
            CSR_ARRIVE_TOL:   tol_ff      <= csr_write_data;
            CSR_LINEAR_GAIN:  lin_gain_ff <= csr_write_data;
            CSR_ANGULAR_GAIN: ang_gain_ff <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ggsc_checker.sv
// Port-level assertions for the steering controller core and their bind.
`default_nettype none

module ggsc_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_ready,
   input wire                               rsp_valid,
   input wire                               rsp_ready,
   input wire [ggsc_pkg::LIN_W-1:0]         rsp_linear_velocity,
   input wire [ggsc_pkg::ANG_W-1:0]         rsp_angular_velocity,
   input wire                               rsp_goal_reached
);
   import ggsc_pkg::*;

   logic seen_reached_ff, seen_reached_in;

   // Remember that an arrival has been reported
   assign seen_reached_in = seen_reached_ff
                          || (rsp_valid && rsp_ready && rsp_goal_reached);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_reached_ff <= 1'b0;
      end else begin
         seen_reached_ff <= seen_reached_in;
      end
   end

   // No result straight out of reset
   a_rsp_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A pose transaction keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("pose accepted on back-to-back cycles");

   // Arrival forces both commands to zero
   a_reached_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_goal_reached) |->
         (rsp_linear_velocity == '0 && rsp_angular_velocity == '0))
      else $error("velocity non-zero with goal reached");

   // Arrival is sticky until reset
   a_reached_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && seen_reached_ff) |-> rsp_goal_reached)
      else $error("goal reached flag dropped");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_linear_velocity) && $stable(rsp_angular_velocity)
          && $stable(rsp_goal_reached)))
      else $error("stalled result changed");

endmodule

bind go_to_goal_steering_controller_core ggsc_checker u_ggsc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_ch.valid),
   .req_ready            (req_ch.ready),
   .rsp_valid            (rsp_ch.valid),
   .rsp_ready            (rsp_ch.ready),
   .rsp_linear_velocity  (rsp_ch.linear_velocity),
   .rsp_angular_velocity (rsp_ch.angular_velocity),
   .rsp_goal_reached     (rsp_ch.goal_reached)
);

`default_nettype wire
